>>> sv/assert_macros.svh
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define ICD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define ICD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/icd_pkg.sv
// types and opcode constants for the instruction class decoder
`timescale 1ns / 1ps

package icd_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CLASS_W = 7;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [CLASS_W-1:0] op_class_t;

  typedef struct packed {
    op_class_t op_class;
    logic      bad_opcode;
    word_t     exec_word;
  } dec_res_t;

  localparam op_class_t OP_NOP    = 7'd0;
  localparam op_class_t OP_MOVW   = 7'd1;
  localparam op_class_t OP_MULS   = 7'd2;
  localparam op_class_t OP_MULSU  = 7'd3;
  localparam op_class_t OP_FMUL   = 7'd4;
  localparam op_class_t OP_FMULS  = 7'd5;
  localparam op_class_t OP_FMULSU = 7'd6;
  localparam op_class_t OP_CPC    = 7'd7;
  localparam op_class_t OP_SBC    = 7'd8;
  localparam op_class_t OP_ADD    = 7'd9;
  localparam op_class_t OP_CPSE   = 7'd10;
  localparam op_class_t OP_CP     = 7'd11;
  localparam op_class_t OP_SUB    = 7'd12;
  localparam op_class_t OP_ADC    = 7'd13;
  localparam op_class_t OP_AND    = 7'd14;
  localparam op_class_t OP_EOR    = 7'd15;
  localparam op_class_t OP_OR     = 7'd16;
  localparam op_class_t OP_MOV    = 7'd17;
  localparam op_class_t OP_CPI    = 7'd18;
  localparam op_class_t OP_SBCI   = 7'd19;
  localparam op_class_t OP_SUBI   = 7'd20;
  localparam op_class_t OP_ORI    = 7'd21;
  localparam op_class_t OP_ANDI   = 7'd22;
  localparam op_class_t OP_LDD    = 7'd23;
  localparam op_class_t OP_STD    = 7'd24;
  localparam op_class_t OP_LDS    = 7'd25;
  localparam op_class_t OP_LDZ    = 7'd26;
  localparam op_class_t OP_LPM    = 7'd27;
  localparam op_class_t OP_ELPM   = 7'd28;
  localparam op_class_t OP_LDY    = 7'd29;
  localparam op_class_t OP_LDX    = 7'd30;
  localparam op_class_t OP_POP    = 7'd31;
  localparam op_class_t OP_STS    = 7'd32;
  localparam op_class_t OP_STZ    = 7'd33;
  localparam op_class_t OP_XCH    = 7'd34;
  localparam op_class_t OP_LAS    = 7'd35;
  localparam op_class_t OP_LAC    = 7'd36;
  localparam op_class_t OP_LAT    = 7'd37;
  localparam op_class_t OP_STY    = 7'd38;
  localparam op_class_t OP_STX    = 7'd39;
  localparam op_class_t OP_PUSH   = 7'd40;
  localparam op_class_t OP_BSET   = 7'd41;
  localparam op_class_t OP_BCLR   = 7'd42;
  localparam op_class_t OP_IJMP   = 7'd43;
  localparam op_class_t OP_EIJMP  = 7'd44;
  localparam op_class_t OP_RET    = 7'd45;
  localparam op_class_t OP_ICALL  = 7'd46;
  localparam op_class_t OP_RETI   = 7'd47;
  localparam op_class_t OP_EICALL = 7'd48;
  localparam op_class_t OP_SLEEP  = 7'd49;
  localparam op_class_t OP_BREAK  = 7'd50;
  localparam op_class_t OP_WDR    = 7'd51;
  localparam op_class_t OP_SPM    = 7'd52;
  localparam op_class_t OP_COM    = 7'd53;
  localparam op_class_t OP_NEG    = 7'd54;
  localparam op_class_t OP_SWAP   = 7'd55;
  localparam op_class_t OP_INC    = 7'd56;
  localparam op_class_t OP_ASR    = 7'd57;
  localparam op_class_t OP_LSR    = 7'd58;
  localparam op_class_t OP_ROR    = 7'd59;
  localparam op_class_t OP_DEC    = 7'd60;
  localparam op_class_t OP_DES    = 7'd61;
  localparam op_class_t OP_JMP    = 7'd62;
  localparam op_class_t OP_CALL   = 7'd63;
  localparam op_class_t OP_ADIW   = 7'd64;
  localparam op_class_t OP_SBIW   = 7'd65;
  localparam op_class_t OP_CBI    = 7'd66;
  localparam op_class_t OP_SBIC   = 7'd67;
  localparam op_class_t OP_SBI    = 7'd68;
  localparam op_class_t OP_SBIS   = 7'd69;
  localparam op_class_t OP_MUL    = 7'd70;
  localparam op_class_t OP_IN     = 7'd71;
  localparam op_class_t OP_OUT    = 7'd72;
  localparam op_class_t OP_RJMP   = 7'd73;
  localparam op_class_t OP_RCALL  = 7'd74;
  localparam op_class_t OP_LDI    = 7'd75;
  localparam op_class_t OP_BRANCH = 7'd76;
  localparam op_class_t OP_BLD    = 7'd77;
  localparam op_class_t OP_BST    = 7'd78;
  localparam op_class_t OP_SBRC   = 7'd79;
  localparam op_class_t OP_SBRS   = 7'd80;
  localparam op_class_t OP_LAST   = OP_SBRS;

  // fixed control words of the one-operand row, and the exec words that the implied lpm and elpm forms turn into
  localparam word_t W_IJMP   = 16'h9409;
  localparam word_t W_EIJMP  = 16'h9419;
  localparam word_t W_RET    = 16'h9508;
  localparam word_t W_ICALL  = 16'h9509;
  localparam word_t W_RETI   = 16'h9518;
  localparam word_t W_EICALL = 16'h9519;
  localparam word_t W_SLEEP  = 16'h9588;
  localparam word_t W_BREAK  = 16'h9598;
  localparam word_t W_WDR    = 16'h95a8;
  localparam word_t W_LPM_I  = 16'h95c8;
  localparam word_t W_ELPM_I = 16'h95d8;
  localparam word_t W_SPM    = 16'h95e8;
  localparam word_t W_SPM_Z  = 16'h95f8;
  localparam word_t W_LPM_X  = 16'h9004;
  localparam word_t W_ELPM_X = 16'h9006;

endpackage

>>> sv/icd_if.sv
// valid/ready channel interfaces for instruction words and decode results
`timescale 1ns / 1ps

interface icd_in_if;
  import icd_pkg::*;
  logic  valid;
  logic  ready;
  word_t instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface icd_out_if;
  import icd_pkg::*;
  logic      valid;
  logic      ready;
  op_class_t op_class;
  logic      bad_opcode;
  word_t     exec_word;

  modport source (output valid, output op_class, output bad_opcode, output exec_word,
                  input ready);
  modport sink (input valid, input op_class, input bad_opcode, input exec_word,
                output ready);
endinterface

>>> sv/icd_in_reg.sv
// input register stage holding one instruction word
`timescale 1ns / 1ps

module icd_in_reg
  import icd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  input  word_t up_word,
  output logic  up_ready,
  output logic  dn_valid,
  output word_t dn_word,
  input  logic  dn_ready
);

  logic  valid_r, valid_nxt;
  word_t word_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= up_word;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

>>> sv/icd_decode.sv
// combinational sort of one instruction word into its operation class
`timescale 1ns / 1ps

module icd_decode
  import icd_pkg::*;
(
  input  word_t    word,
  output dec_res_t res
);

  logic [5:0] row;
  logic       b9;
  op_class_t  cls;
  logic       bad;

  assign row = word[15:10];
  assign b9  = word[9];

  always_comb begin
    cls = OP_NOP;
    bad = 1'b0;
    case (row)
      6'h00: begin
        if (word == 16'h0000) begin
          cls = OP_NOP;
        end else if (word[15:8] == 8'h01) begin
          cls = OP_MOVW;
        end else if (word[15:8] == 8'h02) begin
          cls = OP_MULS;
        end else if (word[15:8] == 8'h03) begin
          case ({word[7], word[3]})
            2'b00:   cls = OP_MULSU;
            2'b01:   cls = OP_FMUL;
            2'b10:   cls = OP_FMULS;
            default: cls = OP_FMULSU;
          endcase
        end else begin
          bad = 1'b1;
        end
      end
      6'h01: cls = OP_CPC;
      6'h02: cls = OP_SBC;
      6'h03: cls = OP_ADD;
      6'h04: cls = OP_CPSE;
      6'h05: cls = OP_CP;
      6'h06: cls = OP_SUB;
      6'h07: cls = OP_ADC;
      6'h08: cls = OP_AND;
      6'h09: cls = OP_EOR;
      6'h0a: cls = OP_OR;
      6'h0b: cls = OP_MOV;
      6'h0c, 6'h0d, 6'h0e, 6'h0f: cls = OP_CPI;
      6'h10, 6'h11, 6'h12, 6'h13: cls = OP_SBCI;
      6'h14, 6'h15, 6'h16, 6'h17: cls = OP_SUBI;
      6'h18, 6'h19, 6'h1a, 6'h1b: cls = OP_ORI;
      6'h1c, 6'h1d, 6'h1e, 6'h1f: cls = OP_ANDI;
      6'h20, 6'h21, 6'h22, 6'h23,
      6'h28, 6'h29, 6'h2a, 6'h2b: cls = b9 ? OP_STD : OP_LDD;
      6'h24: begin
        // loads when bit 9 is clear, stores when set
        case ({b9, word[3:0]})
          5'h00:                cls = OP_LDS;
          5'h01, 5'h02:         cls = OP_LDZ;
          5'h04, 5'h05:         cls = OP_LPM;
          5'h06, 5'h07:         cls = OP_ELPM;
          5'h09, 5'h0a:         cls = OP_LDY;
          5'h0c, 5'h0d, 5'h0e:  cls = OP_LDX;
          5'h0f:                cls = OP_POP;
          5'h10:                cls = OP_STS;
          5'h11, 5'h12:         cls = OP_STZ;
          5'h14:                cls = OP_XCH;
          5'h15:                cls = OP_LAS;
          5'h16:                cls = OP_LAC;
          5'h17:                cls = OP_LAT;
          5'h19, 5'h1a:         cls = OP_STY;
          5'h1c, 5'h1d, 5'h1e:  cls = OP_STX;
          5'h1f:                cls = OP_PUSH;
          default:              bad = 1'b1;
        endcase
      end
      6'h25: begin
        if (!b9 && word[3:1] == 3'b100) begin
          // flag ops and the fixed control words
          if (word[15:8] == 8'h94 && word[3:0] == 4'h8) begin
            cls = word[7] ? OP_BCLR : OP_BSET;
          end else begin
            case (word)
              W_IJMP:           cls = OP_IJMP;
              W_EIJMP:          cls = OP_EIJMP;
              W_RET:            cls = OP_RET;
              W_ICALL:          cls = OP_ICALL;
              W_RETI:           cls = OP_RETI;
              W_EICALL:         cls = OP_EICALL;
              W_SLEEP:          cls = OP_SLEEP;
              W_BREAK:          cls = OP_BREAK;
              W_WDR:            cls = OP_WDR;
              W_LPM_I:          cls = OP_LPM;
              W_ELPM_I:         cls = OP_ELPM;
              W_SPM, W_SPM_Z:   cls = OP_SPM;
              default:          bad = 1'b1;
            endcase
          end
        end else if (!b9) begin
          case (word[3:0])
            4'h0:       cls = OP_COM;
            4'h1:       cls = OP_NEG;
            4'h2:       cls = OP_SWAP;
            4'h3:       cls = OP_INC;
            4'h5:       cls = OP_ASR;
            4'h6:       cls = OP_LSR;
            4'h7:       cls = OP_ROR;
            4'ha:       cls = OP_DEC;
            4'hb: begin
              // des only with bit 8 clear
              cls = OP_DES;
              bad = word[8];
            end
            4'hc, 4'hd: cls = OP_JMP;
            4'he, 4'hf: cls = OP_CALL;
            default:    bad = 1'b1;
          endcase
        end else begin
          cls = word[8] ? OP_SBIW : OP_ADIW;
        end
      end
      6'h26: begin
        case (word[9:8])
          2'd0:    cls = OP_CBI;
          2'd1:    cls = OP_SBIC;
          2'd2:    cls = OP_SBI;
          default: cls = OP_SBIS;
        endcase
      end
      6'h27: cls = OP_MUL;
      6'h2c, 6'h2d: cls = OP_IN;
      6'h2e, 6'h2f: cls = OP_OUT;
      6'h30, 6'h31, 6'h32, 6'h33: cls = OP_RJMP;
      6'h34, 6'h35, 6'h36, 6'h37: cls = OP_RCALL;
      6'h38, 6'h39, 6'h3a, 6'h3b: cls = OP_LDI;
      6'h3c, 6'h3d: cls = OP_BRANCH;
      6'h3e: cls = b9 ? OP_BST : OP_BLD;
      6'h3f: begin
        // reserved bit 3 must be clear for skip-if-bit
        if (word[3]) begin
          bad = 1'b1;
        end else begin
          cls = b9 ? OP_SBRS : OP_SBRC;
        end
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    res.op_class   = bad ? OP_NOP : cls;
    res.bad_opcode = bad;
    if (word == W_LPM_I) begin
      res.exec_word = W_LPM_X;
    end else if (word == W_ELPM_I) begin
      res.exec_word = W_ELPM_X;
    end else begin
      res.exec_word = word;
    end
  end

endmodule

>>> sv/icd_out_reg.sv
// result register stage feeding the output channel
`timescale 1ns / 1ps

module icd_out_reg
  import icd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  dec_res_t up_res,
  output logic     up_ready,
  output logic     dn_valid,
  output dec_res_t dn_res,
  input  logic     dn_ready
);

  logic     valid_r, valid_nxt;
  dec_res_t res_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= up_res;
    end
  end

  assign dn_valid = valid_r;
  assign dn_res   = res_r;

endmodule

>>> sv/instruction_class_decoder_core.sv
// top level of the instruction class decoder
//
//   channel   dir  payload                               beat when
//   in_bus    in   instr_word[15:0]                      valid && ready
//   out_bus   out  op_class[6:0] bad_opcode exec_word    valid && ready
//
// one beat per cycle sustained while out_bus is not stalled; an input beat reaches
// the result through the input register, the decode logic and the result register
// ready is combinational back through both register stages, so a stall on
// the output holds both stages and no beat is lost
// rst_n is synchronous; it empties both stages
`timescale 1ns / 1ps

module instruction_class_decoder_core
  import icd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  icd_in_if.sink    in_bus,
  icd_out_if.source out_bus
);

  logic     s1_valid;
  logic     s1_ready;
  word_t    s1_word;
  dec_res_t dec_res;
  dec_res_t out_res;

  icd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_bus.valid),
    .up_word  (in_bus.instr_word),
    .up_ready (in_bus.ready),
    .dn_valid (s1_valid),
    .dn_word  (s1_word),
    .dn_ready (s1_ready)
  );

  icd_decode u_decode (
    .word (s1_word),
    .res  (dec_res)
  );

  icd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_res   (dec_res),
    .up_ready (s1_ready),
    .dn_valid (out_bus.valid),
    .dn_res   (out_res),
    .dn_ready (out_bus.ready)
  );

  assign out_bus.op_class   = out_res.op_class;
  assign out_bus.bad_opcode = out_res.bad_opcode;
  assign out_bus.exec_word  = out_res.exec_word;

endmodule

>>> sv/icd_checker.sv
// port-level checks for the instruction class decoder, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module icd_checker
  import icd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input op_class_t out_op_class,
  input logic      out_bad_opcode,
  input word_t     out_exec_word
);

  // rejected words report class zero
  `ICD_ASSERT(a_bad_class_zero, out_valid && out_bad_opcode |-> out_op_class == OP_NOP, "bad opcode with nonzero class")

  // class code stays inside the defined set
  `ICD_ASSERT(a_class_range, out_valid |-> out_op_class <= OP_LAST, "class code out of range")

  // a stalled result beat holds
  `ICD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_op_class) && $stable(out_bad_opcode) && $stable(out_exec_word), "stalled result changed")

  // both stages empty straight after reset, so nothing can come out and input is open
  `ICD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind instruction_class_decoder_core icd_checker u_icd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_op_class   (out_bus.op_class),
  .out_bad_opcode (out_bus.bad_opcode),
  .out_exec_word  (out_bus.exec_word)
);
